// ----- rtl/smc_pkg.sv -----
// Shared types and constants for the sprite mask collision block.
package smc_pkg;

  localparam int COORD_W   = 13;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int BOX_W     = 7;
  localparam int OP_W      = 2;
  localparam int ROW_IDX_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd1;

  localparam logic [BOX_W-1:0] BOX_RESET = 7'd64;

  // column alignment of the two mask rows for the compare unit
  typedef struct packed {
    logic             shift_b;
    logic [BOX_W-1:0] shamt;
    logic [BOX_W-1:0] span;
  } smc_align_t;

endpackage

// ----- rtl/smc_ram.sv -----
// Generic simple dual-port RAM with registered read.
module smc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/smc_row_unit.sv -----
// Shared shift and compare unit: tests one aligned pair of mask rows.
module smc_row_unit #(
  parameter int MASK_SIZE = 64
) (
  input  logic [MASK_SIZE-1:0] row_a,
  input  logic [MASK_SIZE-1:0] row_b,
  input  smc_pkg::smc_align_t  align,
  output logic                 match
);

  logic [MASK_SIZE-1:0] shifted;
  logic [MASK_SIZE-1:0] other;
  logic [MASK_SIZE-1:0] colmask;

  always_comb begin
    shifted = align.shift_b ? (row_b >> align.shamt) : (row_a >> align.shamt);
    other   = align.shift_b ? row_a : row_b;
    for (int i = 0; i < MASK_SIZE; i++) begin
      colmask[i] = (smc_pkg::BOX_W'(i) < align.span);
    end
    match = |(shifted & other & colmask);
  end

endmodule

// ----- rtl/sprite_mask_collision.sv -----
// Top level: pixel-exact sprite collision test with row-serial mask scan.
//
// For loads (op 0, op 1) and the unused op, the result beat is
// offered on the next cycle. A test whose boxes are apart or only touch
// goes through the setup state and then offers its result beat. Otherwise
// the test goes on to the scan state over the N overlap rows that fall
// inside the masks (at most MASK_SIZE), then offers its result beat: each
// cycle reads one row from each mask RAM, and the shift and compare unit
// checks that row pair on the next cycle.
// in_ready is low while a test runs and while an earlier result beat is
// still waiting to be taken. Mask RAMs are not cleared; reading a row that
// was never loaded gives an undefined answer. cfg_ready is always high.
module sprite_mask_collision #(
  parameter int MASK_SIZE = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [smc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smc_pkg::BOX_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [smc_pkg::OP_W-1:0]          op,
  input  logic [smc_pkg::ROW_IDX_W-1:0]     row_index,
  input  logic [63:0]                       row_bits,
  input  logic signed [smc_pkg::COORD_W-1:0] a_x,
  input  logic signed [smc_pkg::COORD_W-1:0] a_y,
  input  logic signed [smc_pkg::COORD_W-1:0] b_x,
  input  logic signed [smc_pkg::COORD_W-1:0] b_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit
);

  localparam int AW = $clog2(MASK_SIZE);
  localparam int BW = smc_pkg::BOX_W;
  localparam int DW = smc_pkg::DIFF_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [1:0]           state;
  logic                 res_valid;
  logic                 rd_valid;
  logic [BW-1:0]        box_width;
  logic [BW-1:0]        box_height;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  logic [BW-1:0]        ra;
  logic [BW-1:0]        rb;
  logic [BW-1:0]        rows_left;
  logic                 acc;
  smc_pkg::smc_align_t  align;

  logic                 in_fire;
  logic                 row_ok;
  logic                 we_a;
  logic                 we_b;
  logic [DW-1:0]        adx;
  logic [DW-1:0]        ady;
  logic                 can_issue;
  logic                 match;
  logic [MASK_SIZE-1:0] rdata_a;
  logic [MASK_SIZE-1:0] rdata_b;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && (!res_valid || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = res_valid;

  assign row_ok = ({1'b0, row_index} < BW'(MASK_SIZE));
  assign we_a   = in_fire && (op == smc_pkg::OP_LOAD_A) && row_ok;
  assign we_b   = in_fire && (op == smc_pkg::OP_LOAD_B) && row_ok;

  assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);

  assign can_issue = (rows_left != '0) && (ra < BW'(MASK_SIZE)) && (rb < BW'(MASK_SIZE));

  smc_ram #(.WIDTH(MASK_SIZE), .DEPTH(MASK_SIZE)) u_mask_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (row_index[AW-1:0]),
    .wdata (row_bits[MASK_SIZE-1:0]),
    .raddr (ra[AW-1:0]),
    .rdata (rdata_a)
  );

  smc_ram #(.WIDTH(MASK_SIZE), .DEPTH(MASK_SIZE)) u_mask_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (row_index[AW-1:0]),
    .wdata (row_bits[MASK_SIZE-1:0]),
    .raddr (rb[AW-1:0]),
    .rdata (rdata_b)
  );

  smc_row_unit #(.MASK_SIZE(MASK_SIZE)) u_row_unit (
    .row_a (rdata_a),
    .row_b (rdata_b),
    .align (align),
    .match (match)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      rd_valid   <= 1'b0;
      box_width  <= smc_pkg::BOX_RESET;
      box_height <= smc_pkg::BOX_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          smc_pkg::REG_BOX_WIDTH:  box_width  <= cfg_data;
          smc_pkg::REG_BOX_HEIGHT: box_height <= cfg_data;
          default: ;
        endcase
      end

      // a load or unused op taken this cycle sets a fresh beat below
      if (res_valid && out_ready && !(in_fire && (op != smc_pkg::OP_TEST))) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (op)
              smc_pkg::OP_TEST: begin
                dx    <= DW'(b_x) - DW'(a_x);
                dy    <= DW'(b_y) - DW'(a_y);
                acc   <= 1'b0;
                state <= S_SETUP;
              end
              default: begin
                res_valid <= 1'b1;
                hit       <= 1'b0;
              end
            endcase
          end
        end
        S_SETUP: begin
          // boxes that are apart or only touch have an empty overlap
          if ((adx < DW'(box_width)) && (ady < DW'(box_height))) begin
            align.shift_b <= dx[DW-1];
            align.shamt   <= adx[BW-1:0];
            align.span    <= box_width - adx[BW-1:0];
            ra            <= dy[DW-1] ? '0 : ady[BW-1:0];
            rb            <= dy[DW-1] ? ady[BW-1:0] : '0;
            rows_left     <= box_height - ady[BW-1:0];
            state         <= S_SCAN;
          end else begin
            res_valid <= 1'b1;
            hit       <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (rd_valid) begin
            acc <= acc | match;
          end
          if (can_issue) begin
            ra        <= ra + 1'b1;
            rb        <= rb + 1'b1;
            rows_left <= rows_left - 1'b1;
            rd_valid  <= 1'b1;
          end else begin
            rd_valid <= 1'b0;
            if (!rd_valid) begin
              res_valid <= 1'b1;
              hit       <= acc;
              state     <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
